// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("assertion failed");
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/scpts_pkg.sv =====
`timescale 1ns / 1ps
package scpts_pkg;

	// Frame geometry
	localparam int FRAME_BYTES = 7;
	localparam int IDX_W = $clog2(FRAME_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

	// Item kinds
	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_RX_BYTE = 3'd1,
		KIND_SELECT  = 3'd2,
		KIND_RELEASE = 3'd3,
		KIND_MONITOR = 3'd4
	} kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MIN_VOLTAGE = 2'd0,
		CFG_HOLD_LIMIT  = 2'd1,
		CFG_MAGIC_FIRST = 2'd2,
		CFG_MAGIC_LAST  = 2'd3
	} cfg_idx_t;

	// Status frame byte positions
	localparam logic [IDX_W-1:0] ST_MAGIC_FIRST = IDX_W'(0);
	localparam logic [IDX_W-1:0] ST_VOLT_LO     = IDX_W'(1);
	localparam logic [IDX_W-1:0] ST_VOLT_HI     = IDX_W'(2);
	localparam logic [IDX_W-1:0] ST_REM_LO      = IDX_W'(3);
	localparam logic [IDX_W-1:0] ST_REM_HI      = IDX_W'(4);
	localparam logic [IDX_W-1:0] ST_SHUTDOWN    = IDX_W'(5);

	// Command bits
	localparam int CMD_START_BIT  = 0;
	localparam int CMD_STOP_BIT   = 1;
	localparam int CMD_REPEAT_BIT = 2;

	// Reset values
	localparam logic [15:0] MIN_VOLTAGE_RST = 16'd6000;
	localparam logic [15:0] HOLD_LIMIT_RST  = 16'd2000;
	localparam logic [7:0]  MAGIC_FIRST_RST = 8'h31;
	localparam logic [7:0]  MAGIC_LAST_RST  = 8'h41;
	localparam logic [15:0] PERIOD_RST      = 16'd1000;
	localparam logic [15:0] HIGH_RST        = 16'd500;
	localparam logic [15:0] RELOAD_RST      = 16'd10;

	// ADC code to millivolts: code * 2143 >> 8 (about 8.37 mV per LSB)
	localparam logic [11:0] ADC_SCALE = 12'd2143;
	localparam int ADC_SHIFT = 8;

endpackage

// ===== rtl/core/spi_commanded_pulse_train_supervisor.sv =====
`timescale 1ns / 1ps
// SPI-commanded pulse train supervisor. Each item (timer tick, SPI byte,
// select edge or monitor sample) is captured in an input register and
// processed once no stalled result holds the result register, which
// updates the state and loads the result register; one item is accepted
// every clock as long as results are taken, because the whole update is
// one pass of counter, compare and mux logic. A 7-byte command frame
// (command, period, on-time, count, little endian) is interpreted on select
// release while the status frame (magic, voltage, remaining pulses, shutdown
// flag, magic) is loaded byte by byte on tx_byte. Configuration writes are
// always ready and are meant for idle periods.
`include "assert_macros.svh"

module spi_commanded_pulse_train_supervisor (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  rx_byte,
	input  logic [9:0]  adc_code,
	input  logic        master_on,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pulse_level,
	output logic [7:0]  tx_byte,
	output logic        tx_load,
	output logic [15:0] pulses_left,
	output logic        train_running,
	output logic        shutdown_flag,
	// Configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IDX_W = scpts_pkg::IDX_W;
	localparam int NB = scpts_pkg::FRAME_BYTES;

	// Configuration registers
	logic [15:0] min_voltage_q, hold_limit_q;
	logic [7:0]  magic_first_q, magic_last_q;

	// Input stage
	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [7:0]  rx_s1;
	logic [9:0]  adc_s1;
	logic        master_s1;

	// State
	logic [15:0] phase_q, remaining_q, period_q, high_q, reload_q;
	logic        running_q, repeat_q, selected_q, shutdown_q;
	logic [7:0]  frame_q [NB];
	logic [IDX_W-1:0] byte_index_q;
	logic [15:0] voltage_q, off_count_q;
	logic [7:0]  tx_hold_q;
	logic        out_valid_q, pulse_q, load_q;

	// Next state
	logic [15:0] phase_d, remaining_d, period_d, high_d, reload_d;
	logic        running_d, repeat_d, selected_d, shutdown_d;
	logic [7:0]  frame_d [NB];
	logic [IDX_W-1:0] byte_index_d, wr_idx, nxt_idx;
	logic [15:0] voltage_d, off_count_d;
	logic [7:0]  tx_hold_d, cmd, status_sel;
	logic        load_d, pulse_d;
	logic [15:0] rem_dec, high_m1;
	logic [21:0] mv_prod;
	logic [15:0] mv;

	logic accept_in, advance;

	// Handshake
	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign accept_in = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_voltage_q <= scpts_pkg::MIN_VOLTAGE_RST;
			hold_limit_q  <= scpts_pkg::HOLD_LIMIT_RST;
			magic_first_q <= scpts_pkg::MAGIC_FIRST_RST;
			magic_last_q  <= scpts_pkg::MAGIC_LAST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				scpts_pkg::CFG_MIN_VOLTAGE: min_voltage_q <= cfg_data;
				scpts_pkg::CFG_HOLD_LIMIT:  hold_limit_q <= cfg_data;
				scpts_pkg::CFG_MAGIC_FIRST: magic_first_q <= cfg_data[7:0];
				scpts_pkg::CFG_MAGIC_LAST:  magic_last_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			kind_s1   <= kind;
			rx_s1     <= rx_byte;
			adc_s1    <= adc_code;
			master_s1 <= master_on;
		end
	end

	// Millivolt conversion and helpers
	assign mv_prod = 22'(adc_s1) * 22'(scpts_pkg::ADC_SCALE);
	assign mv      = 16'(mv_prod >> scpts_pkg::ADC_SHIFT);
	assign rem_dec = remaining_q - 16'd1;
	assign cmd     = frame_q[0];
	assign wr_idx  = (byte_index_q > scpts_pkg::LAST_IDX) ? scpts_pkg::LAST_IDX : byte_index_q;
	assign nxt_idx = wr_idx + IDX_W'(1);

	// Status byte for the next slot
	always_comb begin
		case (nxt_idx)
			scpts_pkg::ST_MAGIC_FIRST: status_sel = magic_first_q;
			scpts_pkg::ST_VOLT_LO:     status_sel = voltage_q[7:0];
			scpts_pkg::ST_VOLT_HI:     status_sel = voltage_q[15:8];
			scpts_pkg::ST_REM_LO:      status_sel = remaining_q[7:0];
			scpts_pkg::ST_REM_HI:      status_sel = remaining_q[15:8];
			scpts_pkg::ST_SHUTDOWN:    status_sel = {7'd0, shutdown_q};
			default:                   status_sel = magic_last_q;
		endcase
	end

	// Item processing
	always_comb begin
		phase_d      = phase_q;
		remaining_d  = remaining_q;
		running_d    = running_q;
		period_d     = period_q;
		high_d       = high_q;
		reload_d     = reload_q;
		repeat_d     = repeat_q;
		frame_d      = frame_q;
		byte_index_d = byte_index_q;
		selected_d   = selected_q;
		voltage_d    = voltage_q;
		shutdown_d   = shutdown_q;
		off_count_d  = off_count_q;
		tx_hold_d    = tx_hold_q;
		load_d       = 1'b0;
		case (kind_s1)
			scpts_pkg::KIND_TICK: begin
				if (running_q) begin
					if (phase_q == period_q - 16'd1) begin
						phase_d = '0;
						if (rem_dec == 16'd0) begin
							if (repeat_q) begin
								remaining_d = reload_q;
							end else begin
								remaining_d = rem_dec;
								running_d   = 1'b0;
							end
						end else begin
							remaining_d = rem_dec;
						end
					end else begin
						phase_d = phase_q + 16'd1;
					end
				end
			end
			scpts_pkg::KIND_RX_BYTE: begin
				frame_d[wr_idx] = rx_s1;
				if (wr_idx != scpts_pkg::LAST_IDX) begin
					tx_hold_d    = status_sel;
					load_d       = 1'b1;
					byte_index_d = nxt_idx;
				end else begin
					byte_index_d = wr_idx;
				end
			end
			scpts_pkg::KIND_SELECT: begin
				selected_d = 1'b1;
				tx_hold_d  = magic_first_q;
				load_d     = 1'b1;
			end
			scpts_pkg::KIND_RELEASE: begin
				selected_d   = 1'b0;
				byte_index_d = '0;
				if (cmd != 8'd0) begin
					period_d = {frame_q[2], frame_q[1]};
					high_d   = {frame_q[4], frame_q[3]};
					reload_d = {frame_q[6], frame_q[5]};
				end
				repeat_d = cmd[scpts_pkg::CMD_REPEAT_BIT];
				if (cmd[scpts_pkg::CMD_START_BIT]) begin
					remaining_d = reload_d;
					phase_d     = '0;
					running_d   = 1'b1;
				end
				// stop wins over start
				if (cmd[scpts_pkg::CMD_STOP_BIT]) begin
					running_d = 1'b0;
				end
			end
			scpts_pkg::KIND_MONITOR: begin
				if (!selected_q) begin
					voltage_d = mv;
				end
				if (mv < min_voltage_q || off_count_q > hold_limit_q) begin
					shutdown_d = 1'b1;
				end
				// off count saturates
				if (!master_s1) begin
					if (off_count_q != 16'hFFFF) begin
						off_count_d = off_count_q + 16'd1;
					end
				end else begin
					off_count_d = '0;
				end
			end
			default: ;
		endcase
	end

	// Output level after this item (on-time 0 means always high while running)
	assign high_m1 = high_d - 16'd1;
	assign pulse_d = running_d && (phase_d <= high_m1);

	// State and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			remaining_q  <= '0;
			running_q    <= 1'b0;
			period_q     <= scpts_pkg::PERIOD_RST;
			high_q       <= scpts_pkg::HIGH_RST;
			reload_q     <= scpts_pkg::RELOAD_RST;
			repeat_q     <= 1'b0;
			frame_q      <= '{default: '0};
			byte_index_q <= '0;
			selected_q   <= 1'b0;
			voltage_q    <= '0;
			shutdown_q   <= 1'b0;
			off_count_q  <= '0;
			tx_hold_q    <= '0;
			pulse_q      <= 1'b0;
			load_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				phase_q      <= phase_d;
				remaining_q  <= remaining_d;
				running_q    <= running_d;
				period_q     <= period_d;
				high_q       <= high_d;
				reload_q     <= reload_d;
				repeat_q     <= repeat_d;
				frame_q      <= frame_d;
				byte_index_q <= byte_index_d;
				selected_q   <= selected_d;
				voltage_q    <= voltage_d;
				shutdown_q   <= shutdown_d;
				off_count_q  <= off_count_d;
				tx_hold_q    <= tx_hold_d;
				pulse_q      <= pulse_d;
				load_q       <= load_d;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// Result ports
	assign out_valid     = out_valid_q;
	assign pulse_level   = pulse_q;
	assign tx_byte       = tx_hold_q;
	assign tx_load       = load_q;
	assign pulses_left   = remaining_q;
	assign train_running = running_q;
	assign shutdown_flag = shutdown_q;

	// Checks
	`ASSERT_NEVER(a_idx_range, clk, arst_n, byte_index_q > scpts_pkg::LAST_IDX)
	`ASSERT_NEVER(a_pulse_needs_run, clk, arst_n, out_valid && pulse_level && !train_running)
	`ASSERT_NEVER(a_shutdown_sticky, clk, arst_n, $fell(shutdown_q))
	`ASSERT_IMPLIES(a_stall_full, clk, arst_n, in_stall, valid_s1 && out_valid_q)

endmodule
